// File: rtl/core/sobel_edge_magnitude_u8_assert.svh
// assertion macros for the sobel edge magnitude block
// used by the port checker; expects clk and rst_n in scope
`ifndef SOBEL_EDGE_MAGNITUDE_U8_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_U8_ASSERT_SVH

// same-cycle implication, off while in reset
`define SEM_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel edge check failed");

// next-cycle implication, off while in reset
`define SEM_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel edge check failed");

// next-cycle implication that watches the reset itself
`define SEM_CHK_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sobel edge reset check failed");

`endif

// File: rtl/core/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
// no dependencies
`default_nettype none

package sem_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 16;
  localparam int COL_W = 11;
  localparam int FW_W  = 12;
  localparam int FH_W  = 16;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [FW_W-1:0]  fw_t;
  typedef logic [FH_W-1:0]  fh_t;

  // two previous columns: [0..2] older top/mid/bot, [3..5] newer top/mid/bot
  typedef logic [5:0][PIX_W-1:0] win_t;

  // register index decoded from paddr
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  localparam fw_t  WIDTH_RESET  = 12'd640;
  localparam fh_t  HEIGHT_RESET = 16'd480;
  localparam pix_t PIX_SAT      = 8'hFF;

  // up to three results caused by one pixel
  // slot 0: computed pixel (or row-0 zero), slot 1: right border zero,
  // slot 2: bottom row zero
  typedef struct packed {
    logic [2:0] mask;
    pix_t       val;
    row_t       a_row;
    col_t       a_col;
    row_t       b_row;
    row_t       c_row;
    col_t       col;
    logic       done;
  } burst_t;

endpackage

`default_nettype wire

// File: rtl/core/sobel_edge_magnitude_u8.sv
// top level of the streaming 3x3 sobel edge magnitude block
// depends on sem_pkg, sem_linebuf, sem_kernel, sem_outq
//
// usage:
//   grey pixels enter in raster order on in_pixel_in (valid/stall request
//   channel); results leave on the out_ channel tagged with row, column and
//   a frame_done flag on the last pixel of the frame.
//   frame_width and frame_height are written over the apb port (byte
//   address 0 and 4) while the block is idle; pready is always high.
// timing:
//   a request is taken every cycle while in_stall is low. the line store read
//   is issued when the pixel is taken; the next cycle the sobel sum is formed
//   from the read data, and once the burst holder is free the pixel's results
//   are latched into it, from where the first of them moves on into the
//   output register.
//   a pixel from row 2 on at the last column, or on the last row past column
//   0, causes two or three results; the output register sends one per cycle
//   while out_stall is low, and the input waits until all have moved on.
// reset and stall:
//   reset clears the counters, the window and all valid flags and restores
//   width 640 / height 480. the line stores need no clearing: read data is
//   only used from entries already written. while out_stall is high the
//   output holds and, once the burst and pipe registers fill, in_stall rises.
`default_nettype none

module sobel_edge_magnitude_u8 #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire              clk,
  input  wire              rst_n,
  // configuration
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [2:0]        paddr,
  input  wire [31:0]       pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pixel input
  input  wire              in_valid,
  output logic             in_stall,
  input  sem_pkg::pix_t    in_pixel_in,
  // result output
  output logic             out_valid,
  input  wire              out_stall,
  output sem_pkg::pix_t    out_edge_value,
  output sem_pkg::row_t    out_row,
  output sem_pkg::col_t    out_col,
  output logic             out_frame_done
);
  import sem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > FW_W) ? AW + 1 : FW_W;

  // configuration registers
  fw_t      frame_width_r;
  fh_t      frame_height_r;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  // frame position of the next pixel
  logic [AW-1:0] col_cnt_r, col_cnt_nxt;
  row_t          row_cnt_r, row_cnt_nxt;

  // effective geometry
  logic [CW-1:0] fw_ext, w_eff, w_m1, c_ext;
  fh_t           h_eff, h_m1;
  logic          last_col, last_row, is_r0, is_ge2, inner;

  // pipe register: pixel waiting for its line store data
  logic          s1_v_r, s1_v_nxt;
  pix_t          s1_pix_r;
  logic [AW-1:0] s1_col_r;
  row_t          s1_row_r;
  logic          s1_r0_r, s1_ge2_r, s1_cge1_r, s1_inner_r, s1_lcol_r, s1_lrow_r;

  logic          accept, s1_adv, s1_free, q_free;
  win_t          win_r;
  pix_t          top, mid, kmag;
  burst_t        burst;
  logic [AW+10:0] col_wide, colm1_wide;

  // ---------------- configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = {20'd0, frame_width_r};
      REG_HEIGHT: prdata = {16'd0, frame_height_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_WIDTH) begin
        frame_width_r <= pwdata[FW_W-1:0];
      end else begin
        frame_height_r <= pwdata[FH_W-1:0];
      end
    end
  end

  // ---------------- geometry and position flags
  always_comb begin
    fw_ext = CW'(frame_width_r);
    if (fw_ext < CW'(3)) begin
      w_eff = CW'(3);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    w_m1  = w_eff - CW'(1);
    h_eff = (frame_height_r < 16'd3) ? 16'd3 : frame_height_r;
    h_m1  = h_eff - 16'd1;
    c_ext = CW'(col_cnt_r);

    // a count at or past the end counts as the last column / row
    last_col = (c_ext >= w_m1);
    last_row = (row_cnt_r >= h_m1);
    is_r0    = (row_cnt_r == '0);
    is_ge2   = (row_cnt_r[ROW_W-1:1] != '0);
    inner    = (c_ext >= CW'(2)) && (c_ext <= w_m1) && (row_cnt_r <= h_m1);

    if (last_col) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = last_row ? '0 : row_cnt_r + 16'd1;
    end else begin
      col_cnt_nxt = col_cnt_r + AW'(1);
      row_cnt_nxt = row_cnt_r;
    end
  end

  // ---------------- handshake
  assign s1_adv   = s1_v_r && q_free;
  assign s1_free  = !s1_v_r || s1_adv;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      win_r     <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      // slide the window by one column
      if (s1_adv) begin
        win_r <= {s1_pix_r, mid, top, win_r[5], win_r[4], win_r[3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pixel_in;
      s1_col_r   <= col_cnt_r;
      s1_row_r   <= row_cnt_r;
      s1_r0_r    <= is_r0;
      s1_ge2_r   <= is_ge2;
      s1_cge1_r  <= (col_cnt_r != '0);
      s1_inner_r <= inner;
      s1_lcol_r  <= last_col;
      s1_lrow_r  <= last_row;
    end
  end

  // ---------------- line stores
  // the read of a pixel and the write-back of the one before it never hit
  // the same entry (width is at least three), so no forwarding is needed
  sem_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col_cnt_r),
    .wr_en     (s1_adv),
    .wr_addr   (s1_col_r),
    .wr_upper  (mid),
    .wr_middle (s1_pix_r),
    .rd_upper  (top),
    .rd_middle (mid)
  );

  sem_kernel u_kernel (
    .win (win_r),
    .top (top),
    .mid (mid),
    .bot (s1_pix_r),
    .mag (kmag)
  );

  // ---------------- result burst of the pixel in the pipe register
  always_comb begin
    col_wide   = {{11{1'b0}}, s1_col_r};
    colm1_wide = {{11{1'b0}}, s1_col_r - AW'(1)};
    burst.mask[0] = s1_r0_r || (s1_ge2_r && s1_cge1_r);
    burst.mask[1] = s1_ge2_r && s1_lcol_r;
    burst.mask[2] = s1_ge2_r && s1_lrow_r;
    burst.val     = (s1_ge2_r && s1_inner_r) ? kmag : '0;
    burst.a_row   = s1_r0_r ? '0 : s1_row_r - 16'd1;
    burst.a_col   = s1_r0_r ? col_wide[COL_W-1:0] : colm1_wide[COL_W-1:0];
    burst.b_row   = s1_row_r - 16'd1;
    burst.c_row   = s1_row_r;
    burst.col     = col_wide[COL_W-1:0];
    burst.done    = s1_lcol_r;
  end

  sem_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s1_adv),
    .burst          (burst),
    .free           (q_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_edge_value (out_edge_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_done (out_frame_done)
  );

endmodule

`default_nettype wire

// File: rtl/core/sem_linebuf.sv
// two line stores (upper and middle row), one synchronous read port each
// with registered data and one write port; uses sem_pkg
`default_nettype none

module sem_linebuf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire              clk,
  input  wire              rd_en,
  input  wire [AW-1:0]     rd_addr,
  input  wire              wr_en,
  input  wire [AW-1:0]     wr_addr,
  input  sem_pkg::pix_t    wr_upper,
  input  sem_pkg::pix_t    wr_middle,
  output sem_pkg::pix_t    rd_upper,
  output sem_pkg::pix_t    rd_middle
);
  import sem_pkg::*;

  pix_t upper_mem  [DEPTH];
  pix_t middle_mem [DEPTH];
  pix_t upper_q_r;
  pix_t middle_q_r;

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q_r <= upper_mem[rd_addr];
    end
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_upper;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      middle_q_r <= middle_mem[rd_addr];
    end
    if (wr_en) begin
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  assign rd_upper  = upper_q_r;
  assign rd_middle = middle_q_r;

endmodule

`default_nettype wire

// File: rtl/core/sem_kernel.sv
// 3x3 sobel |gx|+|gy| saturated to 8 bits
// uses sem_pkg
`default_nettype none

module sem_kernel (
  input  sem_pkg::win_t win,
  input  sem_pkg::pix_t top,
  input  sem_pkg::pix_t mid,
  input  sem_pkg::pix_t bot,
  output sem_pkg::pix_t mag
);
  import sem_pkg::*;

  logic [9:0]         sum_r_col, sum_l_col, sum_b_row, sum_t_row;
  logic signed [10:0] gx, gy;
  logic [10:0]        gx_neg, gy_neg;
  logic [9:0]         ax, ay;
  logic [10:0]        total;

  always_comb begin
    sum_r_col = {2'b00, top}    + {1'b0, mid, 1'b0}    + {2'b00, bot};
    sum_l_col = {2'b00, win[0]} + {1'b0, win[1], 1'b0} + {2'b00, win[2]};
    sum_b_row = {2'b00, win[2]} + {1'b0, win[5], 1'b0} + {2'b00, bot};
    sum_t_row = {2'b00, win[0]} + {1'b0, win[3], 1'b0} + {2'b00, top};
    gx = $signed({1'b0, sum_r_col}) - $signed({1'b0, sum_l_col});
    gy = $signed({1'b0, sum_b_row}) - $signed({1'b0, sum_t_row});
    gx_neg = 11'd0 - gx;
    gy_neg = 11'd0 - gy;
    ax = gx[10] ? gx_neg[9:0] : gx[9:0];
    ay = gy[10] ? gy_neg[9:0] : gy[9:0];
    total = {1'b0, ax} + {1'b0, ay};
    mag = (total[10:8] != 3'b000) ? PIX_SAT : total[7:0];
  end

endmodule

`default_nettype wire

// File: rtl/core/sem_outq.sv
// result burst holder and output register: hands out the up to three
// results of one pixel one per cycle while out_stall is low; uses sem_pkg
`default_nettype none

module sem_outq (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              load,
  input  sem_pkg::burst_t  burst,
  output logic             free,
  output logic             out_valid,
  input  wire              out_stall,
  output sem_pkg::pix_t    out_edge_value,
  output sem_pkg::row_t    out_row,
  output sem_pkg::col_t    out_col,
  output logic             out_frame_done
);
  import sem_pkg::*;

  burst_t     b_r;
  logic [2:0] mask_r, mask_nxt, mask_after;
  logic       ov_r;
  pix_t       val_r;
  row_t       row_r;
  col_t       col_r;
  logic       done_r;

  logic       out_free, move;
  pix_t       sel_val;
  row_t       sel_row;
  col_t       sel_col;
  logic       sel_done;

  always_comb begin
    out_free = !ov_r || !out_stall;
    move     = (mask_r != 3'b000) && out_free;
    if (mask_r[0]) begin
      sel_val = b_r.val;  sel_row = b_r.a_row; sel_col = b_r.a_col; sel_done = 1'b0;
    end else if (mask_r[1]) begin
      sel_val = '0;       sel_row = b_r.b_row; sel_col = b_r.col;   sel_done = 1'b0;
    end else begin
      sel_val = '0;       sel_row = b_r.c_row; sel_col = b_r.col;   sel_done = b_r.done;
    end
    // clear lowest pending slot once it moves out
    mask_after = move ? (mask_r & (mask_r - 3'd1)) : mask_r;
    free       = (mask_after == 3'b000);
    mask_nxt   = load ? burst.mask : mask_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'b000;
      ov_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (out_free) begin
        ov_r <= move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_r <= burst;
    end
    if (move) begin
      val_r  <= sel_val;
      row_r  <= sel_row;
      col_r  <= sel_col;
      done_r <= sel_done;
    end
  end

  assign out_valid      = ov_r;
  assign out_edge_value = val_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_frame_done = done_r;

endmodule

`default_nettype wire

// File: rtl/core/sem_checker.sv
// port-level checks for the sobel edge magnitude block and its bind
// depends on sobel_edge_magnitude_u8_assert.svh
`default_nettype none

`include "sobel_edge_magnitude_u8_assert.svh"

module sem_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [7:0]  out_edge_value,
  input wire [15:0] out_row,
  input wire [10:0] out_col,
  input wire        out_frame_done,
  input wire        pready
);

  // nothing pending right after reset
  `SEM_CHK_RST(a_reset_clear, !rst_n, !out_valid && !in_stall)

  // first row and first column are border pixels
  `SEM_CHK_NOW(a_border_zero, out_valid && (out_row == 16'd0 || out_col == 11'd0), out_edge_value == 8'd0)

  // the frame closes on a bottom-right border pixel
  `SEM_CHK_NOW(a_done_zero, out_valid && out_frame_done && pready, out_edge_value == 8'd0)

  // a stalled result is held
  `SEM_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_edge_value) && $stable(out_row) && $stable(out_col) && $stable(out_frame_done))

endmodule

bind sobel_edge_magnitude_u8 sem_checker u_sem_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_edge_value (out_edge_value),
  .out_row        (out_row),
  .out_col        (out_col),
  .out_frame_done (out_frame_done),
  .pready         (pready)
);

`default_nettype wire
